/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module of the bank mapper.
// Depends on nothing; included by the checker file by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the asynchronous reset is held.
`define BMAP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define BMAP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bmap_pkg.sv */
// Types and constants of the bank mapper with scanline interrupt.
// Depends on nothing; used by the interfaces, the top level and the checker.
package bmap_pkg;

	localparam int unsigned OPCODE_W   = 2;
	localparam int unsigned ADDR_W     = 16;
	localparam int unsigned DATA_W     = 8;
	localparam int unsigned BANKS_W    = 6;
	localparam int unsigned OFFSET_W   = 19;
	localparam int unsigned CHR_BANK_W = 8;
	localparam int unsigned PRG_BANK_W = 6;
	localparam int unsigned CHR_REGS   = 6;
	localparam int unsigned PRG_REGS   = 2;
	localparam int unsigned SEL_W      = 3;
	localparam int unsigned IRQ_W      = 8;

	typedef enum logic [OPCODE_W-1:0] {
		OP_WRITE = 2'd0,
		OP_TICK  = 2'd1,
		OP_PRG   = 2'd2,
		OP_CHR   = 2'd3
	} opcode_t;

	// Register window selected by CPU address bits 14 and 13.
	typedef enum logic [1:0] {
		RGN_BANK   = 2'd0,
		RGN_MIRROR = 2'd1,
		RGN_IRQ    = 2'd2,
		RGN_IRQEN  = 2'd3
	} region_t;

	localparam logic [SEL_W-1:0] SEL_CHR2 = 3'd2;
	localparam logic [SEL_W-1:0] SEL_PRG0 = 3'd6;

endpackage

/* hw/rtl/bmap_ifs.sv */
// Valid/ready channel interfaces for the bank mapper's request and result words.
// Depends on bmap_pkg for the field widths.
interface bmap_in_if;
	logic                            valid;
	logic                            ready;
	logic [bmap_pkg::OPCODE_W-1:0]   opcode;
	logic [bmap_pkg::ADDR_W-1:0]     address;
	logic [bmap_pkg::DATA_W-1:0]     write_data;
	logic                            a12_level;

	modport source (output valid, opcode, address, write_data, a12_level, input ready);
	modport sink   (input valid, opcode, address, write_data, a12_level, output ready);
	modport mon    (input valid, ready, opcode, address, write_data, a12_level);
endinterface

interface bmap_out_if;
	logic                            valid;
	logic                            ready;
	logic [bmap_pkg::OFFSET_W-1:0]   rom_offset;
	logic                            mirror_horizontal;
	logic                            irq_request;

	modport source (output valid, rom_offset, mirror_horizontal, irq_request, input ready);
	modport sink   (input valid, rom_offset, mirror_horizontal, irq_request, output ready);
	modport mon    (input valid, ready, rom_offset, mirror_horizontal, irq_request);
endinterface

/* hw/rtl/bank_mapper_with_scanline_irq.sv */
// Top level of the cartridge bank mapper with scanline interrupt counter.
// Depends on bmap_pkg and the channel interfaces in bmap_ifs.sv.
//
// Each request word on item is a register write, a PPU tick carrying the A12
// level, a program ROM translation or a character ROM translation. Every
// request word produces exactly one result word on result: the translated ROM
// offset (zero for writes and ticks), the mirroring and the interrupt request
// as they stand after that request.
// A word accepted on item is held in an input register, is processed against
// the mapper state while it sits there and is loaded into the result register
// when that register is free, so one word can be taken every cycle while result
// is not stalled. The result register decouples the two sides: while result is
// stalled the input register still takes one more word, and item.ready drops
// only when both registers are full. cfg_wdata sets the number of 16 KB
// program banks and must be written only while the mapper is idle; the block
// does not enforce this. Reset clears both registers, loads the bank registers
// with their power-up values and sets the bank count to two; no clearing pass
// is needed, so a word can be accepted in the first cycle after reset.
module bank_mapper_with_scanline_irq #(
	parameter int unsigned FILTER_TICKS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bmap_in_if.sink                        item,
	bmap_out_if.source                     result,
	input  logic                           cfg_we,
	input  logic [bmap_pkg::BANKS_W-1:0]   cfg_wdata
);

	localparam int unsigned FiltW = $clog2(FILTER_TICKS + 1);
	localparam logic [FiltW-1:0] FiltLoad = FiltW'(FILTER_TICKS - 1);

	localparam int unsigned AW  = bmap_pkg::ADDR_W;
	localparam int unsigned DW  = bmap_pkg::DATA_W;
	localparam int unsigned CW  = bmap_pkg::CHR_BANK_W;
	localparam int unsigned PW  = bmap_pkg::PRG_BANK_W;
	localparam int unsigned OW  = bmap_pkg::OFFSET_W;
	localparam int unsigned IW  = bmap_pkg::IRQ_W;
	localparam int unsigned SW  = bmap_pkg::SEL_W;

	// Input register.
	logic                             v_s1;
	logic [bmap_pkg::OPCODE_W-1:0]    op_s1;
	logic [AW-1:0]                    addr_s1;
	logic [DW-1:0]                    data_s1;
	logic                             a12_s1;

	// Result register.
	logic                             v_s2;
	logic [OW-1:0]                    off_s2;
	logic                             mirror_s2;
	logic                             irq_s2;

	// Mapper state.
	logic [CW-1:0]                    chr_q [bmap_pkg::CHR_REGS];
	logic [PW-1:0]                    prg_q [bmap_pkg::PRG_REGS];
	logic [SW-1:0]                    sel_q;
	logic [1:0]                       mode_q;
	logic                             mirror_q;
	logic [IW-1:0]                    reload_q;
	logic [IW-1:0]                    count_q;
	logic                             irq_en_q;
	logic                             pending_q;
	logic                             prev_a12_q;
	logic [FiltW-1:0]                 filt_q;
	logic [bmap_pkg::BANKS_W-1:0]     banks_q;

	logic [CW-1:0]                    chr_nxt [bmap_pkg::CHR_REGS];
	logic [PW-1:0]                    prg_nxt [bmap_pkg::PRG_REGS];
	logic [SW-1:0]                    sel_nxt;
	logic [1:0]                       mode_nxt;
	logic                             mirror_nxt;
	logic [IW-1:0]                    reload_nxt;
	logic [IW-1:0]                    count_nxt;
	logic                             irq_en_nxt;
	logic                             pending_nxt;
	logic                             prev_a12_nxt;
	logic [FiltW-1:0]                 filt_nxt;
	logic [OW-1:0]                    off_nxt;

	logic                             adv2;
	logic                             fire1;

	assign adv2       = !v_s2 || result.ready;
	assign fire1      = v_s1 && adv2;
	assign item.ready = !v_s1 || adv2;

	always_comb begin
		logic [PW-1:0] banks2;
		logic [PW-1:0] mask;
		logic [PW-1:0] second_last;
		logic [PW-1:0] prg_pick;
		logic [CW-1:0] chr_bank;
		logic [2:0]    slot;
		logic [SW-1:0] chr_idx;
		logic          rising;
		logic [IW-1:0] count_clk;

		chr_nxt      = chr_q;
		prg_nxt      = prg_q;
		sel_nxt      = sel_q;
		mode_nxt     = mode_q;
		mirror_nxt   = mirror_q;
		reload_nxt   = reload_q;
		count_nxt    = count_q;
		irq_en_nxt   = irq_en_q;
		pending_nxt  = pending_q;
		prev_a12_nxt = prev_a12_q;
		filt_nxt     = filt_q;
		off_nxt      = '0;

		banks2      = {banks_q[PW-2:0], 1'b0};
		mask        = banks2 - PW'(1);
		second_last = banks2 - PW'(2);

		prg_pick = prg_q[0];
		if (addr_s1[14:13] == 2'd3) begin
			prg_pick = mask;
		end else if (addr_s1[14:13] == 2'd1) begin
			prg_pick = prg_q[1];
		end else if ((addr_s1[14:13] == 2'd0) != mode_q[0]) begin
			prg_pick = prg_q[0];
		end else begin
			prg_pick = second_last;
		end

		slot     = addr_s1[12:10] ^ {mode_q[1], 2'b00};
		chr_idx  = slot[2] ? (slot - 3'd2) : {2'b00, slot[1]};
		chr_bank = chr_q[chr_idx] + CW'(!slot[2] && slot[0]);

		rising    = !prev_a12_q && a12_s1 && (filt_q == '0);
		count_clk = (count_q != '0) ? (count_q - IW'(1)) : reload_q;

		if (fire1) begin
			unique case (bmap_pkg::opcode_t'(op_s1))
				bmap_pkg::OP_WRITE: begin
					if (addr_s1[15]) begin
						unique case (bmap_pkg::region_t'(addr_s1[14:13]))
							bmap_pkg::RGN_BANK: begin
								if (!addr_s1[0]) begin
									sel_nxt  = data_s1[SW-1:0];
									mode_nxt = data_s1[7:6];
								end else if (sel_q < bmap_pkg::SEL_CHR2) begin
									chr_nxt[sel_q] = {data_s1[7:1], 1'b0};
								end else if (sel_q < bmap_pkg::SEL_PRG0) begin
									chr_nxt[sel_q] = data_s1;
								end else begin
									prg_nxt[sel_q[0]] = data_s1[PW-1:0] & mask;
								end
							end
							bmap_pkg::RGN_MIRROR: begin
								if (!addr_s1[0]) begin
									mirror_nxt = data_s1[0];
								end
							end
							bmap_pkg::RGN_IRQ: begin
								if (!addr_s1[0]) begin
									reload_nxt = data_s1;
								end else begin
									count_nxt = '0;
								end
							end
							bmap_pkg::RGN_IRQEN: begin
								if (!addr_s1[0]) begin
									irq_en_nxt  = 1'b0;
									pending_nxt = 1'b0;
								end else begin
									irq_en_nxt = 1'b1;
								end
							end
						endcase
					end
				end
				bmap_pkg::OP_TICK: begin
					if (rising) begin
						count_nxt = count_clk;
						if (count_clk == '0 && irq_en_q) begin
							pending_nxt = 1'b1;
						end
						filt_nxt = FiltLoad;
					end else if (filt_q != '0) begin
						filt_nxt = filt_q - FiltW'(1);
					end
					prev_a12_nxt = a12_s1;
				end
				bmap_pkg::OP_PRG: begin
					if (addr_s1[15]) begin
						off_nxt = {prg_pick, addr_s1[12:0]};
					end
				end
				bmap_pkg::OP_CHR: begin
					if (addr_s1[15:13] == 3'd0) begin
						off_nxt = {1'b0, chr_bank, addr_s1[9:0]};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bmap_pkg::CHR_REGS; i++) begin
				chr_q[i] <= CW'(i);
			end
			for (int i = 0; i < bmap_pkg::PRG_REGS; i++) begin
				prg_q[i] <= PW'(i);
			end
			sel_q      <= '0;
			mode_q     <= '0;
			mirror_q   <= 1'b0;
			reload_q   <= '0;
			count_q    <= '0;
			irq_en_q   <= 1'b0;
			pending_q  <= 1'b0;
			prev_a12_q <= 1'b0;
			filt_q     <= '0;
			banks_q    <= bmap_pkg::BANKS_W'(2);
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
		end else begin
			chr_q      <= chr_nxt;
			prg_q      <= prg_nxt;
			sel_q      <= sel_nxt;
			mode_q     <= mode_nxt;
			mirror_q   <= mirror_nxt;
			reload_q   <= reload_nxt;
			count_q    <= count_nxt;
			irq_en_q   <= irq_en_nxt;
			pending_q  <= pending_nxt;
			prev_a12_q <= prev_a12_nxt;
			filt_q     <= filt_nxt;
			if (cfg_we) begin
				banks_q <= cfg_wdata;
			end
			if (item.ready) begin
				v_s1 <= item.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= item.opcode;
			addr_s1 <= item.address;
			data_s1 <= item.write_data;
			a12_s1  <= item.a12_level;
		end
		if (fire1) begin
			off_s2    <= off_nxt;
			mirror_s2 <= mirror_nxt;
			irq_s2    <= pending_nxt && irq_en_nxt;
		end
	end

	assign result.valid             = v_s2;
	assign result.rom_offset        = off_s2;
	assign result.mirror_horizontal = mirror_s2;
	assign result.irq_request       = irq_s2;

endmodule

/* hw/rtl/bmap_checker.sv */
// Port-level checker for the bank mapper, attached to the top level by bind.
// Depends on bmap_pkg, the channel interfaces in bmap_ifs.sv and assert_macros.svh.
`include "assert_macros.svh"

module bmap_checker (
	input logic          clk,
	input logic          arst_n,
	bmap_in_if.sink      item,
	bmap_out_if.source   result
);

	logic                            in_take;
	logic                            out_stall;
	logic [bmap_pkg::OFFSET_W+1:0]   out_word;

	assign in_take   = item.valid && item.ready;
	assign out_stall = result.valid && !result.ready;
	assign out_word  = {result.rom_offset, result.mirror_horizontal, result.irq_request};

	`BMAP_ASSERT(a_out_hold, clk, arst_n, out_stall |=> result.valid, "result word withdrawn")
	`BMAP_ASSERT(a_out_stable, clk, arst_n, out_stall |=> $stable(out_word), "stalled word changed")
	`BMAP_ASSERT(a_stall_cause, clk, arst_n, !item.ready |-> out_stall, "input stalled alone")
	`BMAP_ASSERT(a_latency, clk, arst_n, in_take ##1 result.ready |=> result.valid, "result late")
	`BMAP_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !result.valid, "result valid during reset")

endmodule

bind bank_mapper_with_scanline_irq bmap_checker u_bmap_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result)
);
